### sv/dtq_pkg.sv
// Shared constants, codes and cell bus types of the delta timer queue.
`default_nettype none
package dtq_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int TICK_BITS  = 32;

  localparam int KIND_W = 2;
  localparam int ID_W   = 4;
  localparam int MS_W   = 27;
  localparam int RATE_W = 16;
  localparam int STAT_W = 2;

  localparam int SLOT_W = $clog2(NUM_TIMERS);
  localparam int LEN_W  = $clog2(NUM_TIMERS + 1);

  localparam int MAX_UNITS  = 32'hFFFF_FFFF >> 15;
  localparam int MS_PER_S   = 1000;
  localparam int MAX_MS     = MAX_UNITS * MS_PER_S;
  localparam int RATE_RESET = 32 * 1024;

  // Millisecond conversion: product, then four quotient bits per cycle.
  localparam int PROD_W    = RATE_W + MS_W;
  localparam int DIV_STEPS = (PROD_W + 3) / 4;
  localparam int DIV_W     = 4 * DIV_STEPS;
  localparam int REM_W     = $clog2(MS_PER_S);
  localparam int WIDE_W    = (DIV_W > TICK_BITS) ? DIV_W : TICK_BITS;
  localparam logic [63:0] TICK_MASK = (64'd1 << TICK_BITS) - 64'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK   = 2'd0,
    KIND_START  = 2'd1,
    KIND_CANCEL = 2'd2
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_ACTIVE   = 2'd1,
    ST_INACTIVE = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_t;

  localparam logic EV_ACK    = 1'b0;
  localparam logic EV_EXPIRE = 1'b1;

  typedef logic [TICK_BITS-1:0] tick_t;

  // One queue entry: slot number and ticks after the entry before it.
  typedef struct packed {
    logic [ID_W-1:0] id;
    tick_t           ticks;
  } ent_t;

  // Insertion search token walking down the row.
  typedef struct packed {
    logic  v;
    tick_t rem;
  } tok_t;

  // Rightward shift bus used when an entry is inserted.
  typedef struct packed {
    logic shr;
    ent_t ent;
  } rbus_t;

  // Commands broadcast to the cells.
  typedef struct packed {
    logic            dec;
    logic            cancel;
    logic [ID_W-1:0] id;
  } ctl_t;

endpackage
`default_nettype wire

### sv/dtq_cell.sv
// One cell of the delta list: holds one entry and trades it with its neighbors.
`default_nettype none
module dtq_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          occ,
  input  dtq_pkg::ctl_t  ctl,
  input  dtq_pkg::tok_t  tok_in,
  output dtq_pkg::tok_t  tok_out,
  input  dtq_pkg::rbus_t rb_in,
  output dtq_pkg::rbus_t rb_out,
  input  logic          shl_in,
  output logic          shl_out,
  input  dtq_pkg::ent_t  ent_right,
  output dtq_pkg::ent_t  ent_q,
  output logic          found
);
  import dtq_pkg::*;

  ent_t ent_r, ent_nxt;
  tok_t tok_r;
  logic pass;
  logic match;

  // The token moves on while the entry here expires no later than the new one.
  assign pass  = tok_r.v && occ && (ent_r.ticks <= tok_r.rem);
  assign found = tok_r.v && !pass;
  assign tok_out = '{v: pass, rem: tok_r.rem - ent_r.ticks};

  assign match   = ctl.cancel && occ && (ent_r.id == ctl.id);
  assign shl_out = shl_in | match;

  assign rb_out.shr       = rb_in.shr | found;
  assign rb_out.ent.id    = ent_r.id;
  assign rb_out.ent.ticks = found ? (ent_r.ticks - tok_r.rem) : ent_r.ticks;

  assign ent_q = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (found) begin
      ent_nxt.id    = ctl.id;
      ent_nxt.ticks = tok_r.rem;
    end else if (rb_in.shr) begin
      ent_nxt = rb_in.ent;
    end else if (match) begin
      // The follower inherits the delay of the removed entry.
      ent_nxt.id    = ent_right.id;
      ent_nxt.ticks = ent_right.ticks + ent_r.ticks;
    end else if (shl_in) begin
      ent_nxt = ent_right;
    end else if (ctl.dec && (ent_r.ticks != '0)) begin
      ent_nxt.ticks = ent_r.ticks - TICK_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.v <= 1'b0;
    end else begin
      tok_r <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule
`default_nettype wire

### sv/dtq_conv.sv
// Millisecond to tick converter: one multiply, then division by 1000 in radix 16.
`default_nettype none
module dtq_conv (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [dtq_pkg::RATE_W-1:0] rate,
  input  logic [dtq_pkg::MS_W-1:0]   ms,
  output logic                       done,
  output dtq_pkg::tick_t             ticks
);
  import dtq_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS + 1);
  localparam logic [REM_W:0] Divisor = (REM_W + 1)'(MS_PER_S);

  logic                 busy_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [DIV_W-1:0]     q_r, q_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [PROD_W-1:0]    prod;
  logic [WIDE_W-1:0]    qx;
  logic                 sat;
  tick_t                d;

  assign prod = PROD_W'(rate) * PROD_W'(ms);

  // Four restoring steps per cycle; the dividend shifts out as quotient shifts in.
  always_comb begin
    logic [REM_W:0] t;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    for (int k = 0; k < 4; k++) begin
      t = {rem_nxt, q_nxt[DIV_W-1]};
      q_nxt = {q_nxt[DIV_W-2:0], (t >= Divisor)};
      rem_nxt = (t >= Divisor) ? REM_W'(t - Divisor) : REM_W'(t);
    end
  end

  assign qx    = WIDE_W'(q_r);
  assign sat   = qx > WIDE_W'(TICK_MASK);
  assign d     = sat ? '1 : qx[TICK_BITS-1:0];
  assign ticks = (d == '0) ? TICK_BITS'(1) : d;
  assign done  = busy_r && (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(DIV_STEPS);
      q_r    <= DIV_W'(prod);
      rem_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
      end else begin
        busy_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### sv/delta_timer_queue.sv
// Top level of the delta timer queue: command sequencer, cell row and result register.
//
// A queue of sixteen one-shot timers kept as a delta list in a row of cells, each
// cell holding one slot number and its ticks after the entry ahead of it. Words
// are taken one at a time; in_stall stays high until the current word is done.
// A tick first ages the head entry, then pops each timer that expires on it, one
// per cycle while the result register is free. A cancel passes through the cancel
// state and then the response state. A start computes the product, divides it by
// 1000 (four quotient bits per cycle), hands over the tick count, then the search
// token walks one cell per cycle until it reaches its place; the response follows.
// A rejected start or cancel goes straight to the response. Every result word waits
// in one output register; the sequencer pauses while that register is full and
// stalled. tick_rate may be written at any idle time through cfg_we/cfg_wdata.
`default_nettype none
module delta_timer_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [dtq_pkg::RATE_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [dtq_pkg::KIND_W-1:0] in_kind,
  input  logic [dtq_pkg::ID_W-1:0]   in_timer_id,
  input  logic [dtq_pkg::MS_W-1:0]   in_duration_ms,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_event_res,
  output logic [dtq_pkg::ID_W-1:0]   out_result_timer,
  output logic [dtq_pkg::STAT_W-1:0] out_status,
  output logic                       out_last
);
  import dtq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TDEC,
    S_TSCAN,
    S_CONV,
    S_SRCH,
    S_CNCL,
    S_RESP
  } state_t;

  state_t                 state_r, state_nxt;
  logic [LEN_W-1:0]       len_r, len_nxt;
  logic [NUM_TIMERS-1:0]  active_r, active_nxt;
  logic [ID_W-1:0]        id_r, id_nxt;
  status_t                st_r, st_nxt;
  logic [RATE_W-1:0]      rate_r;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_ev_r, out_ev_nxt;
  logic [ID_W-1:0]        out_id_r, out_id_nxt;
  status_t                out_st_r, out_st_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   out_free;
  logic                   dec, pop, cancel, conv_start, inject;
  logic                   conv_done;
  tick_t                  conv_ticks;
  logic [SLOT_W-1:0]      in_slot;
  logic                   in_oob;
  logic [NUM_TIMERS-1:0]  found;
  logic [NUM_TIMERS-1:0]  occ;

  // Cell row wiring: index i feeds cell i from the left, i+1 from the right.
  tok_t  tok_w [NUM_TIMERS+1];
  rbus_t rb_w  [NUM_TIMERS+1];
  logic  shl_w [NUM_TIMERS+1];
  ent_t  ent_w [NUM_TIMERS+1];
  ctl_t  ctl_bc, ctl_head;

  // The result register can take a new word when empty or being drained now.
  assign out_free = !out_valid_r || !out_stall;

  assign in_stall = (state_r != S_IDLE);
  assign in_slot  = SLOT_W'(in_timer_id);
  assign in_oob   = (32'(in_timer_id) >= 32'(NUM_TIMERS));

  // The head cell alone ages on a tick; cancel compares go to every cell.
  assign ctl_bc   = '{dec: 1'b0, cancel: cancel, id: id_r};
  assign ctl_head = '{dec: dec, cancel: cancel, id: id_r};

  assign tok_w[0]          = '{v: inject, rem: conv_ticks};
  assign rb_w[0]           = '0;
  assign shl_w[0]          = pop;
  assign ent_w[NUM_TIMERS] = '0;

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    assign occ[i] = (LEN_W'(i) < len_r);
    dtq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .occ       (occ[i]),
      .ctl       ((i == 0) ? ctl_head : ctl_bc),
      .tok_in    (tok_w[i]),
      .tok_out   (tok_w[i+1]),
      .rb_in     (rb_w[i]),
      .rb_out    (rb_w[i+1]),
      .shl_in    (shl_w[i]),
      .shl_out   (shl_w[i+1]),
      .ent_right (ent_w[i+1]),
      .ent_q     (ent_w[i]),
      .found     (found[i])
    );
  end

  dtq_conv u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_start),
    .rate  (rate_r),
    .ms    (in_duration_ms),
    .done  (conv_done),
    .ticks (conv_ticks)
  );

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    active_nxt    = active_r;
    id_nxt        = id_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_ev_nxt    = out_ev_r;
    out_id_nxt    = out_id_r;
    out_st_nxt    = out_st_r;
    out_last_nxt  = out_last_r;
    dec           = 1'b0;
    pop           = 1'b0;
    cancel        = 1'b0;
    conv_start    = 1'b0;
    inject        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          id_nxt = in_timer_id;
          case (in_kind)
            KIND_TICK: begin
              if (len_r != '0) begin
                state_nxt = S_TDEC;
              end
            end
            KIND_START: begin
              // Duration is checked before the slot, as the command defines.
              state_nxt = S_RESP;
              if (in_duration_ms > MS_W'(MAX_MS)) begin
                st_nxt = ST_TOO_LONG;
              end else if (in_oob) begin
                st_nxt = ST_INACTIVE;
              end else if (active_r[in_slot] || (len_r == LEN_W'(NUM_TIMERS))) begin
                st_nxt = ST_ACTIVE;
              end else begin
                conv_start = 1'b1;
                state_nxt  = S_CONV;
              end
            end
            KIND_CANCEL: begin
              if (in_oob || !active_r[in_slot]) begin
                st_nxt    = ST_INACTIVE;
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_CNCL;
              end
            end
            default: begin
              // The unused kind code is dropped without a result.
            end
          endcase
        end
      end
      S_TDEC: begin
        dec       = 1'b1;
        state_nxt = S_TSCAN;
      end
      S_TSCAN: begin
        // Pop expired heads one per cycle while the result register is free; the next head tells whether this is last.
        if ((len_r == '0) || (ent_w[0].ticks != '0)) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          pop           = 1'b1;
          len_nxt       = len_r - LEN_W'(1);
          active_nxt[SLOT_W'(ent_w[0].id)] = 1'b0;
          out_valid_nxt = 1'b1;
          out_ev_nxt    = EV_EXPIRE;
          out_id_nxt    = ent_w[0].id;
          out_st_nxt    = ST_OK;
          out_last_nxt  = !((len_r > LEN_W'(1)) && (ent_w[1].ticks == '0));
        end
      end
      S_CONV: begin
        if (conv_done) begin
          inject    = 1'b1;
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        // The cell that stops the token writes the entry and shifts the tail.
        if (found != '0) begin
          len_nxt                    = len_r + LEN_W'(1);
          active_nxt[SLOT_W'(id_r)] = 1'b1;
          st_nxt                     = ST_OK;
          state_nxt                  = S_RESP;
        end
      end
      S_CNCL: begin
        cancel                     = 1'b1;
        len_nxt                    = len_r - LEN_W'(1);
        active_nxt[SLOT_W'(id_r)] = 1'b0;
        st_nxt                     = ST_OK;
        state_nxt                  = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ev_nxt    = EV_ACK;
          out_id_nxt    = id_r;
          out_st_nxt    = st_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      active_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
    id_r       <= id_nxt;
    st_r       <= st_nxt;
    out_ev_r   <= out_ev_nxt;
    out_id_r   <= out_id_nxt;
    out_st_r   <= out_st_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RATE_W'(RATE_RESET);
    end else if (cfg_we) begin
      rate_r <= cfg_wdata;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_res    = out_ev_r;
  assign out_result_timer = out_id_r;
  assign out_status       = out_st_r;
  assign out_last         = out_last_r;

  // At most one cell can stop the search token.
  a_found_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(found))
    else $error("more than one cell claimed the insertion");

  // Each active slot owns exactly one queue entry.
  a_len_active: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(active_r) == 32'(len_r))
    else $error("queue length and active slots disagree");

  // The converter only finishes while the sequencer waits for it.
  a_conv_done: assert property (@(posedge clk) disable iff (!rst_n)
    conv_done |-> (state_r == S_CONV))
    else $error("tick conversion finished outside a start");

  // A search token is only in flight during the search.
  a_token: assert property (@(posedge clk) disable iff (!rst_n)
    (found != '0) |-> (state_r == S_SRCH))
    else $error("insertion outside of a start");

endmodule
`default_nettype wire
